### hdl/u8cpd_pkg.sv
// shared types and constants of the utf-8 code point decoder
package u8cpd_pkg;

	// widths
	localparam int CpWidth  = 21;
	localparam int CntWidth = 3;

	// replacement value for a malformed unit ('?')
	localparam logic [CpWidth-1:0] QMark = 21'd63;

	// most results one byte can cause
	localparam logic [CntWidth-1:0] MaxResults = 3'd4;

	// lead byte masks and patterns
	localparam logic [7:0] Lead2Mask = 8'hE0;
	localparam logic [7:0] Lead2Code = 8'hC0;
	localparam logic [7:0] Lead3Mask = 8'hF0;
	localparam logic [7:0] Lead3Code = 8'hE0;
	localparam logic [7:0] Lead4Mask = 8'hF8;
	localparam logic [7:0] Lead4Code = 8'hF0;
	localparam logic [7:0] ContMask  = 8'hC0;
	localparam logic [7:0] ContCode  = 8'h80;

	// sequence state carried between bytes
	typedef struct packed {
		logic [CpWidth-1:0] partial_value;
		logic [1:0]         bytes_needed;
		logic [1:0]         bytes_taken;
	} state_t;

	// what one byte produces: a run of results, all '?' but the final one
	typedef struct packed {
		logic [CntWidth-1:0] count;
		logic [CpWidth-1:0]  final_cp;
		logic                final_bad;
	} run_t;

endpackage

### hdl/utf8_code_point_decoder_core.sv
// utf-8 code point decoder: byte in, code point runs out
// The first result of an accepted byte appears in the cycle after it is taken.
// Throughput: one byte per cycle while each byte gives at most one result
// and the output is ready; a byte that gives several results (up to four, on
// errors) holds the input while the result register drains its run.
// Reset (arst_n low) closes any open sequence and empties the result register.
module utf8_code_point_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        malformed,
	output logic        run_end
);

	u8cpd_pkg::state_t state_q;
	u8cpd_pkg::state_t state_nxt;
	u8cpd_pkg::run_t   run;

	logic [2:0]  cnt_q;
	logic [20:0] cp_q;
	logic        bad_q;
	logic        in_fire;
	logic        out_fire;
	logic        final_out;

	// byte decode
	u8cpd_step u_step (
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.cur        (state_q),
		.nxt        (state_nxt),
		.run        (run)
	);

	// handshakes: take a new byte once the pending run is gone or leaving
	assign final_out = cnt_q == 3'd1;
	assign out_valid = cnt_q != 3'd0;
	assign in_ready  = (cnt_q == 3'd0) || (out_ready && final_out);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// result run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (in_fire) begin
			cnt_q <= run.count;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// payload of the final result in the run
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cp_q  <= run.final_cp;
			bad_q <= run.final_bad;
		end
	end

	// leading results are replacements, the final one carries the payload
	assign code_point = final_out ? cp_q : u8cpd_pkg::QMark;
	assign malformed  = final_out ? bad_q : 1'b1;
	assign run_end    = final_out;

	// run never longer than four results
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= u8cpd_pkg::MaxResults)
		else $error("result run too long");

	// a non-final result is always followed by more of the run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !run_end |=> out_valid)
		else $error("result run cut short");

	// leading results of a run are replacement marks
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_end |-> malformed && code_point == u8cpd_pkg::QMark)
		else $error("non-final result is not a replacement");

	// no sequence survives the final byte of a text
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_byte |=> state_q.bytes_needed == 2'd0)
		else $error("sequence left open after last byte");

endmodule

### hdl/u8cpd_step.sv
// next-state and result-run logic for one input byte
module u8cpd_step (
	input  logic [7:0]      byte_value,
	input  logic            last_byte,
	input  u8cpd_pkg::state_t cur,
	output u8cpd_pkg::state_t nxt,
	output u8cpd_pkg::run_t   run
);

	// decode of the byte taken as a fresh lead
	logic [2:0]              lead_n;
	logic [20:0]             lead_cp;
	logic                    lead_bad;
	u8cpd_pkg::state_t       lead_st;

	// continuation path
	logic                    is_cont;
	logic [20:0]             cont_pv;
	logic [1:0]              cont_taken;
	logic [1:0]              cont_needed;

	// lead byte classification
	always_comb begin
		lead_n   = 3'd1;
		lead_cp  = u8cpd_pkg::QMark;
		lead_bad = 1'b1;
		lead_st  = '0;
		if (byte_value inside {[8'h00:8'h7F]}) begin
			lead_cp  = {13'd0, byte_value};
			lead_bad = 1'b0;
		end else if ((byte_value & u8cpd_pkg::Lead2Mask) == u8cpd_pkg::Lead2Code) begin
			if (!last_byte) begin
				lead_n                = 3'd0;
				lead_st.partial_value = {16'd0, byte_value[4:0]};
				lead_st.bytes_needed  = 2'd1;
			end
		end else if ((byte_value & u8cpd_pkg::Lead3Mask) == u8cpd_pkg::Lead3Code) begin
			if (!last_byte) begin
				lead_n                = 3'd0;
				lead_st.partial_value = {17'd0, byte_value[3:0]};
				lead_st.bytes_needed  = 2'd2;
			end
		end else if ((byte_value & u8cpd_pkg::Lead4Mask) == u8cpd_pkg::Lead4Code) begin
			if (!last_byte) begin
				lead_n                = 3'd0;
				lead_st.partial_value = {18'd0, byte_value[2:0]};
				lead_st.bytes_needed  = 2'd3;
			end
		end
	end

	// continuation byte folded into the open sequence
	assign is_cont     = (byte_value & u8cpd_pkg::ContMask) == u8cpd_pkg::ContCode;
	assign cont_pv     = {cur.partial_value[14:0], byte_value[5:0]};
	assign cont_taken  = cur.bytes_taken + 2'd1;
	assign cont_needed = cur.bytes_needed - 2'd1;

	// sequence control
	always_comb begin
		nxt           = '0;
		run.count     = 3'd0;
		run.final_cp  = u8cpd_pkg::QMark;
		run.final_bad = 1'b1;
		if (cur.bytes_needed == 2'd0) begin
			nxt           = lead_st;
			run.count     = lead_n;
			run.final_cp  = lead_cp;
			run.final_bad = lead_bad;
		end else if (is_cont) begin
			if (cont_needed == 2'd0) begin
				run.count     = 3'd1;
				run.final_cp  = cont_pv;
				run.final_bad = 1'b0;
			end else if (last_byte) begin
				run.count = {1'b0, cont_taken} + 3'd1;
			end else begin
				nxt.partial_value = cont_pv;
				nxt.bytes_needed  = cont_needed;
				nxt.bytes_taken   = cont_taken;
			end
		end else begin
			// mismatch: flush the open unit, then restart on this byte
			nxt       = lead_st;
			run.count = {1'b0, cur.bytes_taken} + 3'd1 + lead_n;
			if (lead_n != 3'd0) begin
				run.final_cp  = lead_cp;
				run.final_bad = lead_bad;
			end
		end
		// nothing stays open past the end of the text
		if (last_byte) begin
			nxt = '0;
		end
	end

endmodule
